[sv/mctw_pkg.sv]
// ----------------------------------------------------------------------------
// mctw_pkg
// Shared types and codes for the multi-channel task watchdog core.
// ----------------------------------------------------------------------------
`default_nettype none

package mctw_pkg;

  typedef enum logic [2:0] {
    K_REGISTER   = 3'd0,
    K_ENABLE     = 3'd1,
    K_DISABLE    = 3'd2,
    K_SET_PERIOD = 3'd3,
    K_FEED       = 3'd4,
    K_CHECK      = 3'd5,
    K_TICK       = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the channel memories.
  typedef struct packed {
    logic rd_en;
    logic wr_period;
    logic wr_fed;
  } mem_cmd_t;

  // One finished result word from the controller.
  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [3:0] assigned_id;
    logic       timed_out;
    logic       pet_hardware;
    logic       tripped;
  } res_t;

endpackage

`default_nettype wire

[sv/mctw_mem.sv]
// ----------------------------------------------------------------------------
// mctw_mem
// Channel period and last-fed memories, one write port and one registered
// read port each, sharing a single address.
// ----------------------------------------------------------------------------
`default_nettype none

module mctw_mem #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned IDX_W    = 4
) (
  input  wire                     clk_i,
  input  wire mctw_pkg::mem_cmd_t cmd_i,
  input  wire  [IDX_W-1:0]        addr_i,
  input  wire  [31:0]             per_wdata_i,
  input  wire  [31:0]             fed_wdata_i,
  output logic [31:0]             per_rdata_o,
  output logic [31:0]             fed_rdata_o
);

  logic [31:0] per_mem [CHANNELS];
  logic [31:0] fed_mem [CHANNELS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_period) begin
      per_mem[addr_i] <= per_wdata_i;
    end
    if (cmd_i.wr_fed) begin
      fed_mem[addr_i] <= fed_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      per_rdata_o <= per_mem[addr_i];
      fed_rdata_o <= fed_mem[addr_i];
    end
  end

endmodule

`default_nettype wire

[sv/mctw_ctrl.sv]
// ----------------------------------------------------------------------------
// mctw_ctrl
// Command decode, tick counter, enable bits, trip latch and the check scan
// over the channel memories.
// ----------------------------------------------------------------------------
`default_nettype none

module mctw_ctrl #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire  [2:0]              kind_i,
  input  wire  [7:0]              channel_i,
  input  wire  [31:0]             period_i,
  output logic                    idle_o,
  output mctw_pkg::res_t          res_o,
  output mctw_pkg::mem_cmd_t      cmd_o,
  output logic [IDX_W-1:0]        addr_o,
  output logic [31:0]             per_wdata_o,
  output logic [31:0]             fed_wdata_o,
  input  wire  [31:0]             per_rdata_i,
  input  wire  [31:0]             fed_rdata_i
);

  mctw_pkg::ctrl_state_e state_q, state_d;

  logic [31:0]         tick_q, tick_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [CHANNELS-1:0] en_q, en_d;
  logic                trip_q, trip_d;
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    pend_idx_q, pend_idx_d;
  logic                hit_q, hit_d;

  mctw_pkg::kind_e kind;
  logic            id_ok;
  logic            has_room;
  logic            issue;
  logic            scan_done;
  logic [31:0]     elapsed;
  logic [IDX_W-1:0] chan_idx;

  assign kind      = mctw_pkg::kind_e'(kind_i);
  assign id_ok     = {1'b0, channel_i} < 9'(CHANNELS);
  assign has_room  = used_q < CNT_W'(CHANNELS);
  assign chan_idx  = channel_i[IDX_W-1:0];
  assign issue     = scan_q != used_q;
  assign scan_done = !issue && !pend_q;
  assign elapsed   = tick_q - fed_rdata_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mctw_pkg::S_IDLE: begin
        if (start_i && kind == mctw_pkg::K_CHECK && used_q != '0) begin
          state_d = mctw_pkg::S_SCAN;
        end
      end
      mctw_pkg::S_SCAN: begin
        if (scan_done) begin
          state_d = mctw_pkg::S_IDLE;
        end
      end
      default: state_d = mctw_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    tick_d      = tick_q;
    used_d      = used_q;
    en_d        = en_q;
    trip_d      = trip_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    idle_o      = 1'b0;
    cmd_o       = '0;
    addr_o      = chan_idx;
    per_wdata_o = period_i;
    fed_wdata_o = tick_q;
    res_o       = '0;
    res_o.status = mctw_pkg::ST_OK;

    case (state_q)
      mctw_pkg::S_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          res_o.valid = 1'b1;
          case (kind)
            mctw_pkg::K_REGISTER: begin
              if (has_room) begin
                addr_o            = used_q[IDX_W-1:0];
                cmd_o.wr_period   = 1'b1;
                cmd_o.wr_fed      = 1'b1;
                en_d[used_q[IDX_W-1:0]] = 1'b0;
                used_d            = used_q + 1'b1;
                res_o.assigned_id = 4'(used_q);
              end else begin
                res_o.status = mctw_pkg::ST_FULL;
              end
            end
            mctw_pkg::K_ENABLE: begin
              if (id_ok) begin
                cmd_o.wr_fed   = 1'b1;
                en_d[chan_idx] = 1'b1;
              end else begin
                res_o.status = mctw_pkg::ST_BAD_ID;
              end
            end
            mctw_pkg::K_DISABLE: begin
              if (id_ok) begin
                en_d[chan_idx] = 1'b0;
              end else begin
                res_o.status = mctw_pkg::ST_BAD_ID;
              end
            end
            mctw_pkg::K_SET_PERIOD: begin
              if (id_ok) begin
                cmd_o.wr_period = 1'b1;
              end else begin
                res_o.status = mctw_pkg::ST_BAD_ID;
              end
            end
            mctw_pkg::K_FEED: begin
              if (id_ok) begin
                cmd_o.wr_fed = 1'b1;
              end else begin
                res_o.status = mctw_pkg::ST_BAD_ID;
              end
            end
            mctw_pkg::K_CHECK: begin
              if (used_q == '0) begin
                // Nothing registered: the check passes at once.
                res_o.pet_hardware = 1'b1;
              end else begin
                res_o.valid = 1'b0;
                scan_d      = '0;
                hit_d       = 1'b0;
              end
            end
            mctw_pkg::K_TICK: begin
              tick_d = tick_q + 32'd1;
            end
            default: ;
          endcase
        end
        res_o.tripped = trip_q;
      end
      mctw_pkg::S_SCAN: begin
        // Reads are issued one slot a cycle; each compare uses the data
        // returned in the cycle after its read.
        addr_o    = scan_q[IDX_W-1:0];
        cmd_o.rd_en = issue;
        if (issue) begin
          scan_d     = scan_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = scan_q[IDX_W-1:0];
        end
        if (pend_q && en_q[pend_idx_q] && (elapsed > per_rdata_i)) begin
          hit_d = 1'b1;
        end
        if (scan_done) begin
          res_o.valid        = 1'b1;
          res_o.timed_out    = hit_q;
          res_o.pet_hardware = !hit_q;
          trip_d             = trip_q | hit_q;
        end
        res_o.tripped = trip_q | (scan_done & hit_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mctw_pkg::S_IDLE;
      tick_q  <= '0;
      used_q  <= '0;
      en_q    <= '0;
      trip_q  <= 1'b0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      used_q  <= used_d;
      en_q    <= en_d;
      trip_q  <= trip_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
  end

`ifndef NO_ASSERTIONS
  a_trip_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trip_q |=> trip_q)
    else $error("trip latch cleared without reset");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(CHANNELS))
    else $error("registered channel count above table size");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mctw_pkg::S_SCAN |-> scan_q <= used_q)
    else $error("scan pointer ran past registered channels");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == mctw_pkg::S_IDLE)
    else $error("word started while a check is in progress");

  a_check_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.timed_out && res_o.pet_hardware))
    else $error("check reported both timeout and pet");
`endif

endmodule

`default_nettype wire

[sv/multi_channel_task_watchdog_core.sv]
// ----------------------------------------------------------------------------
// multi_channel_task_watchdog_core
// Software task watchdog: channel table in memory, check scan, output stage.
// ----------------------------------------------------------------------------
// Register, enable, disable, set period, feed, tick and unused words give their
//   result through the output register in the cycle after acceptance; one can be
//   taken every cycle while the output word is free or leaving. A check reads one
//   memory slot per registered channel, waits for the read data, does the final
//   compare and then gives its result; with no channel registered it needs no scan; no word is taken meanwhile.
// Reset clears tick, count, enable bits and trip latch; the memories are not cleared.
`default_nettype none

module multi_channel_task_watchdog_core #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  kind_i,
  input  wire  [7:0]  channel_i,
  input  wire  [31:0] period_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  assigned_id_o,
  output logic        timed_out_o,
  output logic        pet_hardware_o,
  output logic        tripped_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(CHANNELS + 1);

  logic               start;
  logic               ctrl_idle;
  mctw_pkg::res_t     res;
  mctw_pkg::mem_cmd_t cmd;
  logic [IdxW-1:0]    mem_addr;
  logic [31:0]        per_wdata;
  logic [31:0]        fed_wdata;
  logic [31:0]        per_rdata;
  logic [31:0]        fed_rdata;

  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q;
  logic [3:0] assigned_q;
  logic       timed_out_q;
  logic       pet_q;
  logic       tripped_q;

  // A new word is taken only when the output word is free or leaving now.
  assign in_ready_o = ctrl_idle && (!out_valid_q || out_ready_i);
  assign start      = in_valid_i && in_ready_o;

  mctw_ctrl #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IdxW),
    .CNT_W    (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_i),
    .channel_i   (channel_i),
    .period_i    (period_i),
    .idle_o      (ctrl_idle),
    .res_o       (res),
    .cmd_o       (cmd),
    .addr_o      (mem_addr),
    .per_wdata_o (per_wdata),
    .fed_wdata_o (fed_wdata),
    .per_rdata_i (per_rdata),
    .fed_rdata_i (fed_rdata)
  );

  mctw_mem #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IdxW)
  ) u_mem (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .addr_i      (mem_addr),
    .per_wdata_i (per_wdata),
    .fed_wdata_i (fed_wdata),
    .per_rdata_o (per_rdata),
    .fed_rdata_o (fed_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q    <= res.status;
      assigned_q  <= res.assigned_id;
      timed_out_q <= res.timed_out;
      pet_q       <= res.pet_hardware;
      tripped_q   <= res.tripped;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign assigned_id_o  = assigned_q;
  assign timed_out_o    = timed_out_q;
  assign pet_hardware_o = pet_q;
  assign tripped_o      = tripped_q;

endmodule

`default_nettype wire
